/* src/touch_pressure_pen_tracker_core_assert.svh */
// Assertion macros for the touch pressure and pen tracker.
// Included by the RTL files that check their own logic; expects clk and rst in scope.
`ifndef TOUCH_PRESSURE_PEN_TRACKER_CORE_ASSERT_SVH
`define TOUCH_PRESSURE_PEN_TRACKER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Checked outside reset.
`define TPPT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define TPPT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPPT_ASSERT(label, prop, msg)
`define TPPT_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

/* src/tppt_pkg.sv */
// Shared types, codes and the microcode table of the touch pressure and pen tracker.
// No dependencies.
package tppt_pkg;

  localparam int ACC_W     = 32;
  localparam int PLATE_W   = 16;
  localparam int THR_W     = 20;
  localparam int LIMIT_W   = 2;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = 6;
  localparam int STEP_W    = 3;
  localparam int OP_W      = 3;
  localparam int COND_W    = 2;
  localparam int EV_W      = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PLATE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PEN_SENSE = 2'd3;

  // Event codes
  localparam logic [EV_W-1:0] EV_NONE = 2'd0;
  localparam logic [EV_W-1:0] EV_DOWN = 2'd1;
  localparam logic [EV_W-1:0] EV_UP   = 2'd2;

  // Datapath operations
  localparam logic [OP_W-1:0] OP_LOAD    = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB     = 3'd1;
  localparam logic [OP_W-1:0] OP_MULX    = 3'd2;
  localparam logic [OP_W-1:0] OP_MULP    = 3'd3;
  localparam logic [OP_W-1:0] OP_DIVINIT = 3'd4;
  localparam logic [OP_W-1:0] OP_DIVSTEP = 3'd5;
  localparam logic [OP_W-1:0] OP_ROUND   = 3'd6;
  localparam logic [OP_W-1:0] OP_DECIDE  = 3'd7;

  // Sequencing conditions
  localparam logic [COND_W-1:0] COND_NEXT     = 2'd0;
  localparam logic [COND_W-1:0] COND_WAIT_IN  = 2'd1;
  localparam logic [COND_W-1:0] COND_LOOP     = 2'd2;
  localparam logic [COND_W-1:0] COND_WAIT_OUT = 2'd3;

  // Program steps
  localparam logic [STEP_W-1:0] STEP_LOAD    = 3'd0;
  localparam logic [STEP_W-1:0] STEP_SUB     = 3'd1;
  localparam logic [STEP_W-1:0] STEP_MULX    = 3'd2;
  localparam logic [STEP_W-1:0] STEP_MULP    = 3'd3;
  localparam logic [STEP_W-1:0] STEP_DIVINIT = 3'd4;
  localparam logic [STEP_W-1:0] STEP_DIVSTEP = 3'd5;
  localparam logic [STEP_W-1:0] STEP_ROUND   = 3'd6;
  localparam logic [STEP_W-1:0] STEP_DECIDE  = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_fire;
    logic div_last;
    logic out_busy;
  } dp_status_t;

  typedef struct packed {
    logic [PLATE_W-1:0] plate;
    logic [THR_W-1:0]   threshold;
    logic [LIMIT_W-1:0] limit;
    logic               pen_sense;
  } cfg_t;

  // Microcode table: one control word per step
  function automatic ctrl_word_t rom_word(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w = '{op: OP_LOAD, cond: COND_WAIT_IN, target: STEP_LOAD};
    case (step)
      STEP_LOAD:    w = '{op: OP_LOAD,    cond: COND_WAIT_IN,  target: STEP_LOAD};
      STEP_SUB:     w = '{op: OP_SUB,     cond: COND_NEXT,     target: STEP_LOAD};
      STEP_MULX:    w = '{op: OP_MULX,    cond: COND_NEXT,     target: STEP_LOAD};
      STEP_MULP:    w = '{op: OP_MULP,    cond: COND_NEXT,     target: STEP_LOAD};
      STEP_DIVINIT: w = '{op: OP_DIVINIT, cond: COND_NEXT,     target: STEP_LOAD};
      STEP_DIVSTEP: w = '{op: OP_DIVSTEP, cond: COND_LOOP,     target: STEP_DIVSTEP};
      STEP_ROUND:   w = '{op: OP_ROUND,   cond: COND_NEXT,     target: STEP_LOAD};
      STEP_DECIDE:  w = '{op: OP_DECIDE,  cond: COND_WAIT_OUT, target: STEP_LOAD};
      default:      w = '{op: OP_LOAD,    cond: COND_WAIT_IN,  target: STEP_LOAD};
    endcase
    return w;
  endfunction

endpackage

/* src/tppt_seq.sv */
// Microcode sequencer: step counter, control table lookup and conditional jumps.
// Depends on tppt_pkg.
module tppt_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  tppt_pkg::dp_status_t  status,
  output tppt_pkg::ctrl_word_t  ctrl
);
  import tppt_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;

  assign ctrl = rom_word(step);

  always_comb begin
    case (ctrl.cond)
      COND_NEXT:     step_next = step + 1'b1;
      COND_WAIT_IN:  step_next = status.in_fire ? step + 1'b1 : step;
      COND_LOOP:     step_next = status.div_last ? step + 1'b1 : ctrl.target;
      COND_WAIT_OUT: step_next = status.out_busy ? step : ctrl.target;
      default:       step_next = STEP_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_LOAD;
    end else begin
      step <= step_next;
    end
  end

endmodule

/* src/tppt_dp.sv */
// Datapath: sample registers, shared multiplier, restoring divider, pen state and result register.
// Depends on tppt_pkg and the assertion macro header.
`include "touch_pressure_pen_tracker_core_assert.svh"
module tppt_dp #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  tppt_pkg::ctrl_word_t                     ctrl,
  input  tppt_pkg::cfg_t                           cfg,
  output tppt_pkg::dp_status_t                     status,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  output logic [((34+SAMPLE_BITS+7)/8)*8-1:0]      m_tdata
);
  import tppt_pkg::*;

  localparam int SB        = SAMPLE_BITS;
  localparam int RES_W     = ACC_W - SB;
  localparam int OUT_BITS  = EV_W + 2*SB + RES_W;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;
  localparam logic [SB-1:0]    FULL_SCALE = {SB{1'b1}};
  localparam logic [ACC_W-1:0] ROUND_ADD  = ACC_W'((64'd1 << (SB - 1)) - 64'd1);

  // Samples of the current poll
  logic [SB-1:0] x_val;
  logic [SB-1:0] y_val;
  logic [SB-1:0] z1_val;
  logic [SB-1:0] z2_val;
  logic          zero_res;

  logic [ACC_W-1:0]     acc;
  logic [ACC_W-1:0]     acc_next;
  logic [SB:0]          rem;
  logic [SB:0]          rem_next;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic [PLATE_W-1:0]   mul_b;
  logic [ACC_W-1:0]     product;
  logic [SB:0]          rem_sh;
  logic                 div_ge;

  logic                 pen_down;
  logic                 pen_down_next;
  logic [LIMIT_W-1:0]   deb_cnt;
  logic [LIMIT_W-1:0]   deb_cnt_next;
  logic [LIMIT_W:0]     deb_inc;
  logic [LIMIT_W-1:0]   deb_sat;
  logic [ACC_W-1:0]     rt_ext;
  logic [EV_W-1:0]      ev;

  logic                 out_valid;
  logic [OUT_W-1:0]     out_data;
  logic                 in_fire;
  logic                 out_busy;
  logic                 dec_go;

  assign s_tready = (ctrl.op == OP_LOAD);
  assign in_fire  = s_tvalid && s_tready;
  assign out_busy = out_valid && !m_tready;
  assign dec_go   = (ctrl.op == OP_DECIDE) && !out_busy;

  assign status.in_fire  = in_fire;
  assign status.div_last = (div_cnt == DIV_CNT_W'(1));
  assign status.out_busy = out_busy;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // Shared multiplier, low word only
  assign mul_b   = (ctrl.op == OP_MULX) ? PLATE_W'(x_val) : cfg.plate;
  assign product = ACC_W'(acc * mul_b);

  // One restoring division step per cycle
  assign rem_sh = {rem[SB-1:0], acc[ACC_W-1]};
  assign div_ge = (rem_sh >= {1'b0, z1_val});

  always_comb begin
    acc_next = acc;
    rem_next = rem;
    case (ctrl.op)
      OP_SUB:     acc_next = ACC_W'(z2_val) - ACC_W'(z1_val);
      OP_MULX:    acc_next = product;
      OP_MULP:    acc_next = product;
      OP_DIVINIT: rem_next = '0;
      OP_DIVSTEP: begin
        acc_next = {acc[ACC_W-2:0], div_ge};
        rem_next = div_ge ? rem_sh - {1'b0, z1_val} : rem_sh;
      end
      OP_ROUND:   acc_next = acc + ROUND_ADD;
      default:    acc_next = acc;
    endcase
  end

  // Pen state decision
  assign rt_ext  = zero_res ? '0 : ACC_W'(acc >> SB);
  assign deb_inc = {1'b0, deb_cnt} + 1'b1;
  assign deb_sat = (deb_inc > {1'b0, cfg.limit}) ? cfg.limit : deb_inc[LIMIT_W-1:0];

  always_comb begin
    pen_down_next = pen_down;
    deb_cnt_next  = deb_cnt;
    ev            = EV_NONE;
    if (rt_ext > ACC_W'(cfg.threshold)) begin
      deb_cnt_next = '0;
      if (pen_down) begin
        ev            = EV_UP;
        pen_down_next = 1'b0;
      end
    end else begin
      deb_cnt_next = deb_sat;
      if (deb_sat >= cfg.limit) begin
        if (rt_ext != '0) begin
          ev            = EV_DOWN;
          pen_down_next = 1'b1;
        end else if (!cfg.pen_sense && pen_down) begin
          ev            = EV_UP;
          pen_down_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_val    <= (s_tdata[SB-1:0] == FULL_SCALE) ? '0 : s_tdata[SB-1:0];
      y_val    <= ~s_tdata[2*SB-1:SB];
      z1_val   <= s_tdata[3*SB-1:2*SB];
      z2_val   <= s_tdata[4*SB-1:3*SB];
      zero_res <= (s_tdata[SB-1:0] == '0) || (s_tdata[SB-1:0] == FULL_SCALE)
                  || (s_tdata[3*SB-1:2*SB] == '0);
    end
    acc <= acc_next;
    rem <= rem_next;
    if (dec_go) begin
      out_data <= OUT_W'({rt_ext[RES_W-1:0], y_val, x_val, ev});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt   <= '0;
      pen_down  <= 1'b0;
      deb_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.op == OP_DIVINIT) begin
        div_cnt <= DIV_CNT_W'(DIV_STEPS);
      end else if (ctrl.op == OP_DIVSTEP) begin
        div_cnt <= div_cnt - 1'b1;
      end
      if (dec_go) begin
        pen_down  <= pen_down_next;
        deb_cnt   <= deb_cnt_next;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `TPPT_ASSERT(a_div_cnt_live, (ctrl.op == OP_DIVSTEP) |-> (div_cnt != '0), "divider overrun")
  `TPPT_ASSERT(a_rem_bound, (ctrl.op == OP_DIVSTEP && !zero_res) |-> (rem < {1'b0, z1_val}), "remainder not below divisor")
  `TPPT_ASSERT(a_down_sets_pen, (dec_go && ev == EV_DOWN) |=> pen_down, "down report without pen down")
  `TPPT_ASSERT(a_result_from_decide, $rose(out_valid) |-> $past(ctrl.op == OP_DECIDE), "result without decision step")
  `TPPT_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !out_valid, "result register not cleared by reset")

endmodule

/* src/touch_pressure_pen_tracker_core.sv */
// Top level of the touch pressure and pen tracker: configuration registers,
// microcode sequencer and datapath. Depends on tppt_pkg, tppt_seq and tppt_dp.

// Each input beat carries one poll of raw conversions (x, y, z1, z2). The block
// inverts y, forces a full-scale x to zero, works out the touch resistance
// ((z2 - z1) * x * plate / z1 + round) >> SAMPLE_BITS in 32-bit wrapping
// arithmetic (zero when x or z1 reads zero), runs the pen debounce and returns
// one result beat per poll: event (none, down, up), x, y and resistance. A
// short microprogram steps a plain datapath: load, subtract, two multiplies on
// one shared multiplier, then a restoring divider that yields one quotient bit
// per cycle, rounding and the pen decision. After the load step a poll runs
// through all the work steps, the divider loop included, before s_tready
// rises again; the result beat appears at that same edge. A finished result
// waits in the output register while the next poll is taken and worked on.
// Configuration writes take effect at once and belong between polls.
module touch_pressure_pen_tracker_core #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  // Poll input; s_tdata from bit 0: x_raw, y_raw, z1_raw, z2_raw
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,
  // Result output; m_tdata from bit 0: event_kind, x_pos, y_pos, resistance
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((34+SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [tppt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tppt_pkg::CFG_W-1:0]          cfg_data
);
  import tppt_pkg::*;

  cfg_t       cfg;
  ctrl_word_t ctrl;
  dp_status_t status;

  // Configuration registers; writes land directly, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.plate     <= '0;
      cfg.threshold <= THR_W'(500);
      cfg.limit     <= LIMIT_W'(2);
      cfg.pen_sense <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PLATE:     cfg.plate     <= cfg_data[PLATE_W-1:0];
        REG_THRESHOLD: cfg.threshold <= cfg_data[THR_W-1:0];
        REG_LIMIT:     cfg.limit     <= cfg_data[LIMIT_W-1:0];
        REG_PEN_SENSE: cfg.pen_sense <= cfg_data[0];
        default:       cfg.pen_sense <= cfg.pen_sense;
      endcase
    end
  end

  // Step counter and control table
  tppt_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // Arithmetic, pen state and result register
  tppt_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .cfg      (cfg),
    .status   (status),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the touch pressure and pen tracker core. Drives polls
// through a directed table and then random pen strokes, and checks every result beat
// against an in-bench tracker model or typed result. Depends on tppt_pkg, core RTL.
`timescale 1ns / 100ps

module tb_top;
  import tppt_pkg::*;

  localparam int SAMPLE_BITS = 12;
  localparam int IN_W        = ((4*SAMPLE_BITS+7)/8)*8;
  localparam int OUT_W       = ((34+SAMPLE_BITS+7)/8)*8;
  localparam logic [11:0] FULL_SCALE = 12'((1 << SAMPLE_BITS) - 1);
  localparam logic [31:0] ROUND_ADD  = 32'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam int RAND_POLLS  = 1450;
  localparam int TAIL_CYCLES = 80;
  localparam int CYCLE_LIMIT = 1000000;

  // One result beat, field by field
  typedef struct packed {
    logic [EV_W-1:0]  ev;
    logic [11:0]      xp;
    logic [11:0]      yp;
    logic [THR_W-1:0] res;
  } report_t;

  // Directed table: either a poll or a register write
  typedef enum logic {ROW_POLL, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
    logic [11:0]          x;
    logic [11:0]          y;
    logic [11:0]          z1;
    logic [11:0]          z2;
    logic                 typed;   // want holds a hand-written result
    report_t              want;
  } dir_row_t;

  localparam int DIR_ROWS = 35;

  // Reset settings first: plate 0, threshold 500, limit 2, no pen sense
  dir_row_t dir_table [DIR_ROWS] = '{
    // plate is 0, so every resistance is 0
    '{ROW_POLL, REG_PLATE, 0, 0, 0, 0, 0, 1'b1, '{EV_NONE, 0, 4095, 0}},
    '{ROW_POLL, REG_PLATE, 0, 4095, 4095, 4095, 4095, 1'b1, '{EV_NONE, 0, 0, 0}},
    '{ROW_POLL, REG_PLATE, 0, 4094, 1, 4095, 0, 1'b1, '{EV_NONE, 4094, 4094, 0}},
    // widest plate, highest threshold, no debounce wait beyond one poll
    '{ROW_REG, REG_PLATE, 65535, 0, 0, 0, 0, 1'b0, '0},
    '{ROW_REG, REG_THRESHOLD, 1048575, 0, 0, 0, 0, 1'b0, '0},
    '{ROW_REG, REG_LIMIT, 1, 0, 0, 0, 0, 1'b0, '0},
    '{ROW_POLL, REG_PLATE, 0, 2048, 2048, 1000, 3000, 1'b0, '0},
    // z2 below z1: the difference wraps
    '{ROW_POLL, REG_PLATE, 0, 4094, 0, 4095, 0, 1'b0, '0},
    // x zero, then x full scale, then z1 zero
    '{ROW_POLL, REG_PLATE, 0, 0, 100, 800, 1200, 1'b0, '0},
    '{ROW_POLL, REG_PLATE, 0, 4095, 100, 800, 1200, 1'b0, '0},
    '{ROW_POLL, REG_PLATE, 0, 1000, 2000, 0, 4095, 1'b0, '0},
    // threshold zero lifts on any resistance; count up to a limit of three
    '{ROW_REG, REG_THRESHOLD, 0, 0, 0, 0, 0, 1'b0, '0},
    '{ROW_REG, REG_LIMIT, 3, 0, 0, 0, 0, 1'b0, '0},
    '{ROW_POLL, REG_PLATE, 0, 2000, 1500, 500, 2500, 1'b0, '0},
    '{ROW_POLL, REG_PLATE, 0, 0, 1500, 500, 2500, 1'b0, '0},
    '{ROW_POLL, REG_PLATE, 0, 0, 1500, 500, 2500, 1'b0, '0},
    '{ROW_POLL, REG_PLATE, 0, 0, 1500, 500, 2500, 1'b0, '0},
    // lower the limit below the count, which then saturates down
    '{ROW_REG, REG_LIMIT, 1, 0, 0, 0, 0, 1'b0, '0},
    '{ROW_POLL, REG_PLATE, 0, 0, 700, 500, 2500, 1'b0, '0},
    '{ROW_REG, REG_THRESHOLD, 1048575, 0, 0, 0, 0, 1'b0, '0},
    '{ROW_POLL, REG_PLATE, 0, 2000, 1500, 500, 2500, 1'b0, '0},
    // pen sense present: zero resistance must not lift the pen
    '{ROW_REG, REG_PEN_SENSE, 1, 0, 0, 0, 0, 1'b0, '0},
    '{ROW_POLL, REG_PLATE, 0, 0, 1500, 500, 2500, 1'b0, '0},
    '{ROW_POLL, REG_PLATE, 0, 2000, 1500, 0, 2500, 1'b0, '0},
    '{ROW_REG, REG_PEN_SENSE, 0, 0, 0, 0, 0, 1'b0, '0},
    '{ROW_POLL, REG_PLATE, 0, 0, 1500, 500, 2500, 1'b0, '0},
    // limit zero: no debouncing at all
    '{ROW_REG, REG_LIMIT, 0, 0, 0, 0, 0, 1'b0, '0},
    '{ROW_POLL, REG_PLATE, 0, 3000, 3000, 300, 4000, 1'b0, '0},
    '{ROW_POLL, REG_PLATE, 0, 4095, 3000, 300, 4000, 1'b0, '0},
    '{ROW_POLL, REG_PLATE, 0, 3000, 3000, 300, 4000, 1'b0, '0},
    '{ROW_REG, REG_THRESHOLD, 0, 0, 0, 0, 0, 1'b0, '0},
    '{ROW_POLL, REG_PLATE, 0, 3000, 3000, 300, 4000, 1'b0, '0},
    // back to the reset settings
    '{ROW_REG, REG_PLATE, 0, 0, 0, 0, 0, 1'b0, '0},
    '{ROW_REG, REG_THRESHOLD, 500, 0, 0, 0, 0, 1'b0, '0},
    '{ROW_REG, REG_LIMIT, 2, 0, 0, 0, 0, 1'b0, '0}
  };

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // Shadow of the configuration and the pen state
  logic [PLATE_W-1:0] plate_ohms   = '0;
  logic [THR_W-1:0]   lift_thr     = 20'd500;
  logic [LIMIT_W-1:0] settle_limit = 2'd2;
  logic               pen_sense    = 1'b0;
  logic               pen_down_q   = 1'b0;
  int                 settle_cnt   = 0;

  report_t pending_reports [$];
  int      fault_count = 0;
  int      cycle_count = 0;
  int      src_idle    = 28;   // percent of cycles the poll source holds off
  int      snk_idle    = 46;   // percent of cycles the result sink stalls
  report_t seen_rep;
  report_t due_rep;

  touch_pressure_pen_tracker_core #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the result of one poll and advance the pen state
  function automatic report_t track_poll(input logic [11:0] xr, input logic [11:0] yr,
                                         input logic [11:0] z1, input logic [11:0] z2);
    report_t     r;
    logic [31:0] acc;
    logic [11:0] xf;
    int          nxt;
    xf   = (xr == FULL_SCALE) ? 12'd0 : xr;
    r.ev = EV_NONE;
    r.xp = xf;
    r.yp = FULL_SCALE - yr;
    if (xf == 12'd0 || z1 == 12'd0) begin
      acc = '0;
    end else begin
      // every step wraps at 32 bits
      acc = 32'(z2) - 32'(z1);
      acc = acc * 32'(xf);
      acc = acc * 32'(plate_ohms);
      acc = acc / 32'(z1);
      acc = acc + ROUND_ADD;
      acc = acc >> SAMPLE_BITS;
    end
    r.res = acc[THR_W-1:0];
    if (acc > 32'(lift_thr)) begin
      settle_cnt = 0;
      if (pen_down_q) begin
        r.ev       = EV_UP;
        pen_down_q = 1'b0;
      end
    end else begin
      nxt        = settle_cnt + 1;
      settle_cnt = (nxt > int'(settle_limit)) ? int'(settle_limit) : nxt;
      if (settle_cnt >= int'(settle_limit)) begin
        if (acc != 0) begin
          pen_down_q = 1'b1;
          r.ev       = EV_DOWN;
        end else if (!pen_sense && pen_down_q) begin
          r.ev       = EV_UP;
          pen_down_q = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // Entered and left at a falling edge. Hold valid until the beat is taken.
  task automatic drive_poll(input logic [11:0] x, input logic [11:0] y,
                            input logic [11:0] z1, input logic [11:0] z2);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {z2, z1, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_poll(input logic [11:0] x, input logic [11:0] y,
                           input logic [11:0] z1, input logic [11:0] z2);
    drive_poll(x, y, z1, z2);
    pending_reports.push_back(track_poll(x, y, z1, z2));
  endtask

  // Drop valid and wait until every outstanding result has come back
  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
  endtask

  // Write one register with the block idle and mirror it in the shadow copy
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_PLATE:     plate_ohms   = val[PLATE_W-1:0];
      REG_THRESHOLD: lift_thr     = val[THR_W-1:0];
      REG_LIMIT:     settle_limit = val[LIMIT_W-1:0];
      REG_PEN_SENSE: pen_sense    = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Pick a fresh setting of all four registers, extremes included
  task automatic shuffle_settings;
    logic [CFG_W-1:0] plate;
    logic [CFG_W-1:0] thr;
    case ($urandom_range(9))
      0:       plate = 20'd0;
      1:       plate = 20'd65535;
      2:       plate = 20'($urandom_range(65535));
      default: plate = 20'($urandom_range(50, 2000));
    endcase
    case ($urandom_range(9))
      0:       thr = 20'd0;
      1:       thr = 20'hFFFFF;
      2:       thr = 20'($urandom_range(20'hFFFFF));
      default: thr = 20'($urandom_range(1500));
    endcase
    set_reg(REG_PLATE, plate);
    set_reg(REG_THRESHOLD, thr);
    set_reg(REG_LIMIT, 20'($urandom_range(3)));
    set_reg(REG_PEN_SENSE, 20'($urandom_range(1)));
  endtask

  // Sink side: stall at random, decided at the falling edge
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_idle);
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reports.size() == 0) begin
        $error("result beat with no poll outstanding: %h", m_tdata);
        fault_count++;
      end else begin
        due_rep  = pending_reports.pop_front();
        seen_rep = m_tdata[$bits(report_t)-1:0];
        seen_rep = '{ev: m_tdata[1:0], xp: m_tdata[13:2], yp: m_tdata[25:14],
                     res: m_tdata[45:26]};
        if (seen_rep.ev !== due_rep.ev) begin
          $error("event_kind: expected %0d, got %0d", due_rep.ev, seen_rep.ev);
          fault_count++;
        end
        if (seen_rep.xp !== due_rep.xp) begin
          $error("x_pos: expected %0d, got %0d", due_rep.xp, seen_rep.xp);
          fault_count++;
        end
        if (seen_rep.yp !== due_rep.yp) begin
          $error("y_pos: expected %0d, got %0d", due_rep.yp, seen_rep.yp);
          fault_count++;
        end
        if (seen_rep.res !== due_rep.res) begin
          $error("resistance: expected %0d, got %0d", due_rep.res, seen_rep.res);
          fault_count++;
        end
      end
    end
  end

  // Watchdog: give up well past the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int          sent;
    int          block_end;
    int          strokes;
    int          lifts;
    logic [11:0] x;
    logic [11:0] z1;
    report_t     predicted;

    // hold reset, then release it at a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: walk the table
    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_REG) begin
        set_reg(dir_table[i].idx, dir_table[i].val);
      end else begin
        drive_poll(dir_table[i].x, dir_table[i].y, dir_table[i].z1, dir_table[i].z2);
        // advance the shadow state even where the result is typed in
        predicted = track_poll(dir_table[i].x, dir_table[i].y,
                               dir_table[i].z1, dir_table[i].z2);
        pending_reports.push_back(dir_table[i].typed ? dir_table[i].want : predicted);
      end
    end

    // Random part: blocks of pen strokes, each block under its own settings
    sent = 0;
    while (sent < RAND_POLLS) begin
      if (sent < RAND_POLLS / 3) begin
        src_idle = 28;
        snk_idle = 46;
      end else if (sent < 2 * RAND_POLLS / 3) begin
        src_idle = 46;
        snk_idle = 28;
      end else begin
        src_idle = 0;
        snk_idle = 0;
      end
      shuffle_settings();
      block_end = sent + $urandom_range(30, 70);
      while (sent < block_end) begin
        if ($urandom_range(99) < 15) begin
          // noise: any raw value at all
          send_poll(12'($urandom_range(4095)), 12'($urandom_range(4095)),
                    12'($urandom_range(4095)), 12'($urandom_range(4095)));
          sent++;
        end else begin
          // pen on the panel for a few polls; a light touch reads a small z1
          strokes = $urandom_range(1, 8);
          repeat (strokes) begin
            x  = 12'($urandom_range(1, 4094));
            z1 = ($urandom_range(9) == 0) ? 12'($urandom_range(1, 50))
                                          : 12'($urandom_range(100, 2000));
            send_poll(x, 12'($urandom_range(4095)), z1,
                      z1 + 12'($urandom_range(4095 - int'(z1))));
            sent++;
          end
          // then lifted: x reads zero or full scale, or z1 reads zero
          lifts = $urandom_range(4);
          repeat (lifts) begin
            case ($urandom_range(2))
              0:       send_poll(12'd0, 12'($urandom_range(4095)),
                                 12'($urandom_range(4095)), 12'($urandom_range(4095)));
              1:       send_poll(FULL_SCALE, 12'($urandom_range(4095)),
                                 12'($urandom_range(4095)), 12'($urandom_range(4095)));
              default: send_poll(12'($urandom_range(4095)), 12'($urandom_range(4095)),
                                 12'd0, 12'($urandom_range(4095)));
            endcase
            sent++;
          end
        end
      end
    end

    // Wait for the last results, then let the block settle
    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fault_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/tppt_pkg.sv
src/tppt_seq.sv
src/tppt_dp.sv
src/touch_pressure_pen_tracker_core.sv
test/tb_top.sv
